// ===== hw/rtl/staged_greedy_graph_coloring_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the staged greedy graph coloring unit
// Concurrent checks clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef STAGED_GREEDY_GRAPH_COLORING_UNIT_DEFINES_SVH
`define STAGED_GREEDY_GRAPH_COLORING_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Hold a property at every clock edge outside reset.
`define SGGC_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sggc check failed");
// Require the consequent in the cycle after the trigger.
`define SGGC_ASSERT_NEXT(label, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("sggc sequence check failed");
`else
`define SGGC_ASSERT(label, prop)
`define SGGC_ASSERT_NEXT(label, trig, cons)
`endif

`endif

// ===== hw/rtl/sggc_pkg.sv =====
// ----------------------------------------------------------------------------
// sggc_pkg
// Operation codes and shared types of the graph coloring unit.
// ----------------------------------------------------------------------------
package sggc_pkg;

    localparam logic [2:0] KIND_PUSH     = 3'd0;
    localparam logic [2:0] KIND_STASH    = 3'd1;
    localparam logic [2:0] KIND_COMMIT   = 3'd2;
    localparam logic [2:0] KIND_CLEAR    = 3'd3;
    localparam logic [2:0] KIND_DISCARD  = 3'd4;
    localparam logic [2:0] KIND_HAS_EDGE = 3'd5;
    localparam logic [2:0] KIND_READ_CLR = 3'd6;

    localparam logic [8:0] COLOR_NONE = 9'h1FF;

    typedef struct packed {
        logic [7:0] first;
        logic [7:0] second;
    } edge_t;

endpackage

// ===== hw/rtl/sggc_req_if.sv =====
// ----------------------------------------------------------------------------
// sggc_req_if
// Operation request channel: kind and two node ids.
// ----------------------------------------------------------------------------
interface sggc_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] node_a;
    logic [7:0] node_b;

    modport source (output valid, output kind, output node_a, output node_b, input ready);
    modport sink   (input valid, input kind, input node_a, input node_b, output ready);
endinterface

// ===== hw/rtl/sggc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// sggc_rsp_if
// Operation result channel: lookup answers, region counts, overflow.
// ----------------------------------------------------------------------------
interface sggc_rsp_if;
    logic              valid;
    logic              ready;
    logic              edge_found;
    logic signed [8:0] node_color;
    logic [10:0]       pending_count;
    logic [10:0]       staged_count;
    logic              overflow;

    modport source (output valid, output edge_found, output node_color,
                    output pending_count, output staged_count, output overflow,
                    input ready);
    modport sink   (input valid, input edge_found, input node_color,
                    input pending_count, input staged_count, input overflow,
                    output ready);
endinterface

// ===== hw/rtl/staged_greedy_graph_coloring_unit.sv =====
// ----------------------------------------------------------------------------
// staged_greedy_graph_coloring_unit
// Edge list in committed/staged/pending regions with greedy node coloring.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                         | handshake
//  req     | in  | kind, node_a, node_b                            | valid/ready
//  rsp     | out | edge_found, node_color, pending_count,          | valid/ready
//          |     | staged_count, overflow                          |
//
//  One transaction at a time. Push, clear, discard, read_color and unused kinds need no walk.
//  Stash moves any pending edges down to the committed boundary. Has_edge scans committed, then pending.
//  Commit reads each staged edge (skipped if an end is out of range); a clashing edge j adds
//  an edge walk over edges 0..j, a mark sweep over all colors and a write of the new color.
//  After reset a clearing pass holds req.ready low.
//  A finished result waits in the output register; the next request is taken meanwhile.
// ----------------------------------------------------------------------------
`include "staged_greedy_graph_coloring_unit_defines.svh"

module staged_greedy_graph_coloring_unit
    import sggc_pkg::*;
#(
    parameter int NODE_COUNT = 256,
    parameter int EDGE_DEPTH = 1024
)(
    input  logic       clk,
    input  logic       rst_n,
    sggc_req_if.sink   req,
    sggc_rsp_if.source rsp
);

    localparam int NIW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int EIW = (EDGE_DEPTH > 1) ? $clog2(EDGE_DEPTH) : 1;
    localparam int EAW = $clog2(EDGE_DEPTH + 1);
    localparam int SCW = NIW + 1;

    localparam logic [3:0] ST_INIT  = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_DONE  = 4'd2;
    localparam logic [3:0] ST_STASH = 4'd3;
    localparam logic [3:0] ST_HAS   = 4'd4;
    localparam logic [3:0] ST_RDC   = 4'd5;
    localparam logic [3:0] ST_CE_RD = 4'd6;
    localparam logic [3:0] ST_CE_A  = 4'd7;
    localparam logic [3:0] ST_CE_B  = 4'd8;
    localparam logic [3:0] ST_CE_W  = 4'd9;
    localparam logic [3:0] ST_CE_WB = 4'd10;
    localparam logic [3:0] ST_MARK  = 4'd11;
    localparam logic [3:0] ST_SWEEP = 4'd12;
    localparam logic [3:0] ST_SETB  = 4'd13;

    typedef struct packed {
        logic           uncol;
        logic [NIW-1:0] idx;
    } color_t;

    // Memories: edge list, per-node colors, per-color neighbor marks
    edge_t  edge_mem  [EDGE_DEPTH];
    color_t color_mem [NODE_COUNT];
    logic   mark_mem  [NODE_COUNT];

    logic           edge_we, color_we, mark_we;
    logic [EIW-1:0] edge_wa, edge_ra;
    edge_t          edge_wd, edge_q;
    logic [NIW-1:0] color_wa, color_ra, mark_wa, mark_ra;
    color_t         color_wd, color_q;
    logic           mark_wd, mark_q;

    always_ff @(posedge clk)
    begin
        if (edge_we)
        begin
            edge_mem[edge_wa] <= edge_wd;
        end
        edge_q <= edge_mem[edge_ra];
    end

    always_ff @(posedge clk)
    begin
        if (color_we)
        begin
            color_mem[color_wa] <= color_wd;
        end
        color_q <= color_mem[color_ra];
    end

    always_ff @(posedge clk)
    begin
        if (mark_we)
        begin
            mark_mem[mark_wa] <= mark_wd;
        end
        mark_q <= mark_mem[mark_ra];
    end

    // Control and payload registers
    logic [3:0]     state_reg, state_next;
    logic [EAW-1:0] committed_reg, committed_next;
    logic [EAW-1:0] staged_reg, staged_next;
    logic [EAW-1:0] total_reg, total_next;
    logic [EAW-1:0] idx_reg, idx_next;
    logic [EAW-1:0] dst_reg, dst_next;
    logic [EAW-1:0] j_reg, j_next;
    logic [SCW-1:0] sidx_reg, sidx_next;
    logic [NIW-1:0] saddr_reg, saddr_next;
    logic [NIW-1:0] free_reg, free_next;
    logic           free_found_reg, free_found_next;
    logic           p1_reg, p1_next;
    logic           p2_reg, p2_next;
    logic           phase_reg, phase_next;
    logic [7:0]     a_reg, a_next;
    logic [7:0]     b_reg, b_next;
    logic [7:0]     ea_reg, ea_next;
    logic [7:0]     eb_reg, eb_next;
    color_t         ca_reg, ca_next;
    color_t         cbn_reg, cbn_next;
    logic           same_reg, same_next;
    logic           res_found_reg, res_found_next;
    logic [8:0]     res_color_reg, res_color_next;
    logic           res_ovf_reg, res_ovf_next;
    logic           out_valid_reg, out_valid_next;
    logic           out_found_reg, out_found_next;
    logic [8:0]     out_color_reg, out_color_next;
    logic [10:0]    out_pend_reg, out_pend_next;
    logic [10:0]    out_stg_reg, out_stg_next;
    logic           out_ovf_reg, out_ovf_next;

    function automatic logic in_range(input logic [7:0] n);
        return 32'(n) < NODE_COUNT;
    endfunction

    color_t ca_fix, cb_fix;
    logic [7:0] nb;
    logic       nb_hit;

    assign req.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        committed_next  = committed_reg;
        staged_next     = staged_reg;
        total_next      = total_reg;
        idx_next        = idx_reg;
        dst_next        = dst_reg;
        j_next          = j_reg;
        sidx_next       = sidx_reg;
        saddr_next      = saddr_reg;
        free_next       = free_reg;
        free_found_next = free_found_reg;
        p1_next         = p1_reg;
        p2_next         = p2_reg;
        phase_next      = phase_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        ea_next         = ea_reg;
        eb_next         = eb_reg;
        ca_next         = ca_reg;
        cbn_next        = cbn_reg;
        same_next       = same_reg;
        res_found_next  = res_found_reg;
        res_color_next  = res_color_reg;
        res_ovf_next    = res_ovf_reg;
        out_found_next  = out_found_reg;
        out_color_next  = out_color_reg;
        out_pend_next   = out_pend_reg;
        out_stg_next    = out_stg_reg;
        out_ovf_next    = out_ovf_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;

        edge_we  = 1'b0;
        edge_wa  = '0;
        edge_wd  = '0;
        edge_ra  = '0;
        color_we = 1'b0;
        color_wa = '0;
        color_wd = '0;
        color_ra = '0;
        mark_we  = 1'b0;
        mark_wa  = '0;
        mark_wd  = 1'b0;
        mark_ra  = '0;

        ca_fix = '0;
        cb_fix = '0;
        nb     = '0;
        nb_hit = 1'b0;

        unique case (state_reg)
            ST_INIT:
            begin
                // Sweep colors to uncolored and marks to clear
                color_we = 1'b1;
                color_wa = NIW'(sidx_reg);
                color_wd = '{uncol: 1'b1, idx: '0};
                mark_we  = 1'b1;
                mark_wa  = NIW'(sidx_reg);
                mark_wd  = 1'b0;
                if (sidx_reg == SCW'(NODE_COUNT - 1))
                begin
                    sidx_next  = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    sidx_next = sidx_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (req.valid)
                begin
                    a_next         = req.node_a;
                    b_next         = req.node_b;
                    res_found_next = 1'b0;
                    res_color_next = '0;
                    res_ovf_next   = 1'b0;
                    state_next     = ST_DONE;
                    unique case (req.kind)
                        KIND_PUSH:
                        begin
                            if (total_reg == EAW'(EDGE_DEPTH))
                            begin
                                res_ovf_next = 1'b1;
                            end
                            else
                            begin
                                edge_we    = 1'b1;
                                edge_wa    = total_reg[EIW-1:0];
                                edge_wd    = '{first: req.node_a, second: req.node_b};
                                total_next = total_reg + 1'b1;
                            end
                        end
                        KIND_STASH:
                        begin
                            idx_next   = staged_reg;
                            dst_next   = committed_reg;
                            p1_next    = 1'b0;
                            state_next = ST_STASH;
                        end
                        KIND_COMMIT:
                        begin
                            total_next = staged_reg;
                            j_next     = committed_reg;
                            state_next = ST_CE_RD;
                        end
                        KIND_CLEAR:
                        begin
                            total_next = staged_reg;
                        end
                        KIND_DISCARD:
                        begin
                            total_next  = committed_reg;
                            staged_next = committed_reg;
                        end
                        KIND_HAS_EDGE:
                        begin
                            idx_next   = '0;
                            phase_next = 1'b0;
                            p1_next    = 1'b0;
                            state_next = ST_HAS;
                        end
                        KIND_READ_CLR:
                        begin
                            if (in_range(req.node_a))
                            begin
                                color_ra   = NIW'(req.node_a);
                                state_next = ST_RDC;
                            end
                            else
                            begin
                                res_color_next = COLOR_NONE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_STASH:
            begin
                // Read pending entries in order, write each one from the committed boundary up in the following cycle
                if (idx_reg < total_reg)
                begin
                    edge_ra  = idx_reg[EIW-1:0];
                    idx_next = idx_reg + 1'b1;
                    p1_next  = 1'b1;
                end
                else
                begin
                    p1_next = 1'b0;
                end
                if (p1_reg)
                begin
                    edge_we  = 1'b1;
                    edge_wa  = dst_reg[EIW-1:0];
                    edge_wd  = edge_q;
                    dst_next = dst_reg + 1'b1;
                end
                if (idx_reg >= total_reg && !p1_reg)
                begin
                    total_next  = dst_reg;
                    staged_next = dst_reg;
                    state_next  = ST_DONE;
                end
            end

            ST_HAS:
            begin
                p1_next = 1'b0;
                if (!phase_reg)
                begin
                    if (idx_reg < committed_reg)
                    begin
                        edge_ra  = idx_reg[EIW-1:0];
                        idx_next = idx_reg + 1'b1;
                        p1_next  = 1'b1;
                    end
                    else
                    begin
                        idx_next   = staged_reg;
                        phase_next = 1'b1;
                    end
                end
                else if (idx_reg < total_reg)
                begin
                    edge_ra  = idx_reg[EIW-1:0];
                    idx_next = idx_reg + 1'b1;
                    p1_next  = 1'b1;
                end
                if (p1_reg)
                begin
                    if ((edge_q.first == a_reg && edge_q.second == b_reg) ||
                        (edge_q.first == b_reg && edge_q.second == a_reg))
                    begin
                        res_found_next = 1'b1;
                    end
                end
                if (phase_reg && idx_reg >= total_reg && !p1_reg)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_RDC:
            begin
                res_color_next = color_q.uncol ? COLOR_NONE : 9'(color_q.idx);
                state_next     = ST_DONE;
            end

            ST_CE_RD:
            begin
                if (j_reg < staged_reg)
                begin
                    edge_ra    = j_reg[EIW-1:0];
                    state_next = ST_CE_A;
                end
                else
                begin
                    committed_next = staged_reg;
                    state_next     = ST_DONE;
                end
            end

            ST_CE_A:
            begin
                ea_next = edge_q.first;
                eb_next = edge_q.second;
                if (in_range(edge_q.first) && in_range(edge_q.second))
                begin
                    color_ra   = NIW'(edge_q.first);
                    state_next = ST_CE_B;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_CE_RD;
                end
            end

            ST_CE_B:
            begin
                ca_next    = color_q;
                color_ra   = NIW'(eb_reg);
                state_next = ST_CE_W;
            end

            ST_CE_W:
            begin
                // Give uncolored ends color 0, write the first end back
                ca_fix    = ca_reg.uncol ? color_t'('0) : ca_reg;
                cb_fix    = color_q.uncol ? color_t'('0) : color_q;
                color_we  = 1'b1;
                color_wa  = NIW'(ea_reg);
                color_wd  = ca_fix;
                cbn_next  = cb_fix;
                same_next = (ca_fix == cb_fix);
                state_next = ST_CE_WB;
            end

            ST_CE_WB:
            begin
                color_we = 1'b1;
                color_wa = NIW'(eb_reg);
                color_wd = cbn_reg;
                if (same_reg)
                begin
                    idx_next   = '0;
                    p1_next    = 1'b0;
                    p2_next    = 1'b0;
                    state_next = ST_MARK;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = ST_CE_RD;
                end
            end

            ST_MARK:
            begin
                // Walk edges 0..j: edge read, neighbor color read, mark write
                if (idx_reg <= j_reg)
                begin
                    edge_ra  = idx_reg[EIW-1:0];
                    idx_next = idx_reg + 1'b1;
                    p1_next  = 1'b1;
                end
                else
                begin
                    p1_next = 1'b0;
                end
                p2_next = 1'b0;
                if (p1_reg)
                begin
                    if (edge_q.first == eb_reg)
                    begin
                        nb     = edge_q.second;
                        nb_hit = 1'b1;
                    end
                    else if (edge_q.second == eb_reg)
                    begin
                        nb     = edge_q.first;
                        nb_hit = 1'b1;
                    end
                    if (nb_hit && in_range(nb))
                    begin
                        color_ra = NIW'(nb);
                        p2_next  = 1'b1;
                    end
                end
                if (p2_reg && !color_q.uncol)
                begin
                    mark_we = 1'b1;
                    mark_wa = color_q.idx;
                    mark_wd = 1'b1;
                end
                if (idx_reg > j_reg && !p1_reg && !p2_reg)
                begin
                    sidx_next       = '0;
                    p1_next         = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = ST_SWEEP;
                end
            end

            ST_SWEEP:
            begin
                // Find the lowest free color and clear each mark behind the read
                if (sidx_reg < SCW'(NODE_COUNT))
                begin
                    mark_ra    = NIW'(sidx_reg);
                    saddr_next = NIW'(sidx_reg);
                    sidx_next  = sidx_reg + 1'b1;
                    p1_next    = 1'b1;
                end
                else
                begin
                    p1_next = 1'b0;
                end
                if (p1_reg)
                begin
                    mark_we = 1'b1;
                    mark_wa = saddr_reg;
                    mark_wd = 1'b0;
                    if (!mark_q && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_next       = saddr_reg;
                    end
                end
                if (sidx_reg >= SCW'(NODE_COUNT) && !p1_reg)
                begin
                    state_next = ST_SETB;
                end
            end

            ST_SETB:
            begin
                if (free_found_reg)
                begin
                    color_we = 1'b1;
                    color_wa = NIW'(eb_reg);
                    color_wd = '{uncol: 1'b0, idx: free_reg};
                end
                j_next     = j_reg + 1'b1;
                state_next = ST_CE_RD;
            end

            ST_DONE:
            begin
                // Load the output register once it is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = res_found_reg;
                    out_color_next = res_color_reg;
                    out_pend_next  = 11'(total_reg - staged_reg);
                    out_stg_next   = 11'(staged_reg - committed_reg);
                    out_ovf_next   = res_ovf_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            committed_reg  <= '0;
            staged_reg     <= '0;
            total_reg      <= '0;
            idx_reg        <= '0;
            dst_reg        <= '0;
            j_reg          <= '0;
            sidx_reg       <= '0;
            free_found_reg <= 1'b0;
            p1_reg         <= 1'b0;
            p2_reg         <= 1'b0;
            phase_reg      <= 1'b0;
            same_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            committed_reg  <= committed_next;
            staged_reg     <= staged_next;
            total_reg      <= total_next;
            idx_reg        <= idx_next;
            dst_reg        <= dst_next;
            j_reg          <= j_next;
            sidx_reg       <= sidx_next;
            free_found_reg <= free_found_next;
            p1_reg         <= p1_next;
            p2_reg         <= p2_next;
            phase_reg      <= phase_next;
            same_reg       <= same_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        saddr_reg     <= saddr_next;
        free_reg      <= free_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        ea_reg        <= ea_next;
        eb_reg        <= eb_next;
        ca_reg        <= ca_next;
        cbn_reg       <= cbn_next;
        res_found_reg <= res_found_next;
        res_color_reg <= res_color_next;
        res_ovf_reg   <= res_ovf_next;
        out_found_reg <= out_found_next;
        out_color_reg <= out_color_next;
        out_pend_reg  <= out_pend_next;
        out_stg_reg   <= out_stg_next;
        out_ovf_reg   <= out_ovf_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.edge_found    = out_found_reg;
    assign rsp.node_color    = out_color_reg;
    assign rsp.pending_count = out_pend_reg;
    assign rsp.staged_count  = out_stg_reg;
    assign rsp.overflow      = out_ovf_reg;

    // Region boundaries stay ordered and inside the edge memory
    `SGGC_ASSERT(a_region_order, committed_reg <= staged_reg && staged_reg <= total_reg)
    `SGGC_ASSERT(a_total_bound, total_reg <= EAW'(EDGE_DEPTH))
    // An accepted request always leaves the idle state
    `SGGC_ASSERT_NEXT(a_accept_busy, req.valid && req.ready, state_reg != ST_IDLE)

endmodule
